### rtl/jbl_pkg.sv
// Package for the JSON byte lexer: token kinds, error codes, lexer modes and widths.
// Used by rtl/json_byte_lexer.sv and rtl/json_byte_lexer_checker.sv.
`timescale 1ns / 1ps
package jbl_pkg;

    localparam int LINE_BITS   = 20;
    localparam int COLUMN_BITS = 16;

    typedef enum logic [3:0] {
        TK_LBRACE   = 4'd0,
        TK_RBRACE   = 4'd1,
        TK_LBRACKET = 4'd2,
        TK_RBRACKET = 4'd3,
        TK_COMMA    = 4'd4,
        TK_COLON    = 4'd5,
        TK_CHAR     = 4'd6,
        TK_STR_END  = 4'd7,
        TK_NUMBER   = 4'd8,
        TK_TRUE     = 4'd9,
        TK_FALSE    = 4'd10,
        TK_NULL     = 4'd11,
        TK_ERROR    = 4'd12
    } token_kind_t;

    typedef enum logic [2:0] {
        ER_NONE     = 3'd0,
        ER_BAD_CHAR = 3'd1,
        ER_EARLY    = 3'd2,
        ER_BAD_HEX  = 3'd3,
        ER_BAD_NUM  = 3'd4,
        ER_BAD_TRUE = 3'd5,
        ER_BAD_FALSE= 3'd6,
        ER_BAD_NULL = 3'd7
    } error_code_t;

    typedef enum logic [3:0] {
        M_IDLE   = 4'd0,
        M_STR    = 4'd1,
        M_ESC    = 4'd2,
        M_HEX    = 4'd3,
        M_KEYW   = 4'd4,
        M_NSIGN  = 4'd5,
        M_NZERO  = 4'd6,
        M_NINT   = 4'd7,
        M_NDOT   = 4'd8,
        M_NFRAC  = 4'd9,
        M_NE     = 4'd10,
        M_NESIGN = 4'd11,
        M_NEXP   = 4'd12,
        M_HALT   = 4'd13
    } lex_mode_t;

    typedef struct packed {
        logic                   final_of_run;
        logic                   saturated;
        logic signed [15:0]     exponent;
        logic [63:0]            mantissa;
        logic                   is_negative;
        logic [15:0]            column_count;
        logic [19:0]            line_count;
        logic [7:0]             char_value;
        error_code_t            error_code;
        token_kind_t            token_kind;
    } token_t;

    // Expected keyword character, indexed by keyword and position.
    function automatic logic [7:0] kw_char(input logic [1:0] sel, input logic [2:0] pos);
        logic [7:0] c;
        c = 8'h00;
        unique case (sel)
            2'd0:
            begin
                case (pos)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
            2'd1:
            begin
                case (pos)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                case (pos)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

endpackage

### rtl/json_byte_lexer.sv
// Top level of the JSON byte lexer: byte input stream, token output stream.
// Depends on rtl/jbl_pkg.sv.
//
// Channel | Direction | tdata                               | tuser | tlast
// s_axis  | in        | text_byte                           | -     | end_of_document
// m_axis  | out       | kind,err,char,line,col,neg,mant,exp,sat | -  | final_of_run
//
// Bytes go through an input register; the token pair for a byte is formed from it.
// A byte is lexed when the two-entry output queue is empty or empties in that cycle,
// so a byte waits until every token of the byte before it has been or is being taken.
// A byte's first token is offered from the output queue, after the input register.
// A stalled consumer holds one byte in the input register and then drops s_axis_tready.
// Reset puts the lexer between tokens on line 1, column 0, with the queue empty.
`timescale 1ns / 1ps
module json_byte_lexer
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [7:0]   s_axis_tdata,   // text_byte
    input  logic         s_axis_tlast,   // end_of_document
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // token_kind[3:0], error_code[6:4], char_value[14:7], line_count[34:15],
    // column_count[50:35], is_negative[51], mantissa[115:52], exponent[131:116],
    // saturated[132], zero fill to 135
    output logic [135:0] m_axis_tdata,
    output logic         m_axis_tlast    // final_of_run
);
    import jbl_pkg::*;

    localparam logic [63:0] MANT_MAX = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MANT_LIM = 64'd1844674407370955161;
    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [COLUMN_BITS-1:0] COL_MAX  = '1;

    // Input register.
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_last_reg;

    // Lexer state.
    lex_mode_t              mode_reg, mode_next;
    logic [2:0]             sub_reg, sub_next;
    logic [1:0]             ksel_reg, ksel_next;
    logic                   sign_reg, sign_next;
    logic [63:0]            mant_reg, mant_next;
    logic [15:0]            frac_reg, frac_next;
    logic [15:0]            exp_reg, exp_next;
    logic                   esign_reg, esign_next;
    logic                   ovf_reg, ovf_next;
    logic [LINE_BITS-1:0]   line_reg, line_next;
    logic [COLUMN_BITS-1:0] col_reg, col_next;

    // Output queue of two entries.
    token_t     q_data_reg [2];
    logic [1:0] q_cnt_reg;
    logic       q_head_reg;

    token_t     tok [2];
    logic [1:0] tok_cnt;
    logic       fire;
    logic       room;

    assign room          = (q_cnt_reg == 2'd0);
    assign fire          = in_valid_reg && (room ||
                           (m_axis_tvalid && m_axis_tready && q_cnt_reg == 2'd1));
    assign s_axis_tready = !in_valid_reg || fire;

    // Combinational token formation.
    always_comb
    begin
        logic [7:0]             c;
        logic                   dig;
        logic [3:0]             d;
        logic [COLUMN_BITS-1:0] nxt;
        logic                   nl;
        logic                   redo;
        logic [2:0]             pos;
        logic signed [17:0]     e;
        logic                   esat;
        logic [67:0]            mprod;
        logic [19:0]            eprod;
        logic                   idle_run;
        c      = in_byte_reg;
        dig    = (c >= "0") && (c <= "9");
        d      = dig ? c[3:0] : 4'd0;
        nxt    = (col_reg < COL_MAX) ? col_reg + 1'b1 : col_reg;
        nl     = 1'b0;
        redo   = 1'b0;
        pos    = 3'd0;
        e      = '0;
        esat   = 1'b0;
        mprod  = '0;
        eprod  = '0;
        idle_run = 1'b0;
        tok_cnt = 2'd0;
        for (int i = 0; i < 2; i++)
        begin
            tok[i] = '0;
        end
        mode_next = mode_reg;
        sub_next  = sub_reg;
        ksel_next = ksel_reg;
        sign_next = sign_reg;
        mant_next = mant_reg;
        frac_next = frac_reg;
        exp_next  = exp_reg;
        esign_next= esign_reg;
        ovf_next  = ovf_reg;
        line_next = line_reg;
        col_next  = col_reg;

        if (mode_reg == M_IDLE)
        begin
            idle_run = 1'b1;
        end
        else if (mode_reg == M_STR)
        begin
            if (c == "\\")
            begin
                mode_next = M_ESC;
            end
            else if (c == "\"")
            begin
                tok[0].token_kind = TK_STR_END;
                tok_cnt = 2'd1;
                mode_next = M_IDLE;
            end
            else
            begin
                tok[0].token_kind = TK_CHAR;
                tok[0].char_value = c;
                tok_cnt = 2'd1;
            end
        end
        else if (mode_reg == M_ESC)
        begin
            mode_next = M_STR;
            tok[0].token_kind = TK_CHAR;
            tok_cnt = 2'd1;
            case (c)
                "\"", "\\", "/": tok[0].char_value = c;
                "b": tok[0].char_value = 8'd8;
                "f": tok[0].char_value = 8'd12;
                "n": tok[0].char_value = 8'd10;
                "r": tok[0].char_value = 8'd13;
                "t": tok[0].char_value = 8'd9;
                "u":
                begin
                    tok_cnt = 2'd0;
                    mode_next = M_HEX;
                    sub_next = 3'd0;
                end
                default: tok_cnt = 2'd0;
            endcase
        end
        else if (mode_reg == M_HEX)
        begin
            if (!(dig || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
            begin
                tok[0].token_kind = TK_ERROR;
                tok[0].error_code = ER_BAD_HEX;
                tok_cnt = 2'd1;
                mode_next = M_HALT;
            end
            else
            begin
                sub_next = sub_reg + 3'd1;
                if (sub_reg >= 3'd3)
                begin
                    mode_next = M_STR;
                end
            end
        end
        else if (mode_reg == M_KEYW)
        begin
            pos = (sub_reg > 3'd4) ? 3'd4 : sub_reg;
            if (c != kw_char(ksel_reg, pos))
            begin
                tok[0].token_kind = TK_ERROR;
                tok[0].error_code = error_code_t'(3'd5 + {1'b0, ksel_reg});
                tok_cnt = 2'd1;
                mode_next = M_HALT;
            end
            else
            begin
                sub_next = pos + 3'd1;
                if (kw_char(ksel_reg, pos + 3'd1) == 8'h00)
                begin
                    tok[0].token_kind = token_kind_t'(4'd9 + {2'b00, ksel_reg});
                    tok_cnt = 2'd1;
                    mode_next = M_IDLE;
                end
            end
        end
        else if (mode_reg == M_HALT)
        begin
            tok_cnt = 2'd0;
        end
        else
        begin
            mprod = {4'd0, mant_reg} * 68'd10 + 68'(d);
            eprod = {4'd0, exp_reg} * 20'd10 + 20'(d);
            unique case (mode_reg)
                M_NSIGN:
                begin
                    if (c == "0") mode_next = M_NZERO;
                    else if (dig)
                    begin
                        mant_next = mprod[63:0];
                        mode_next = M_NINT;
                    end
                    else redo = 1'b1;
                end
                M_NZERO, M_NINT:
                begin
                    if (dig && mode_reg == M_NINT)
                    begin
                        if (mant_reg > MANT_LIM || mprod[67:64] != 4'd0)
                        begin
                            mant_next = MANT_MAX;
                            ovf_next = 1'b1;
                        end
                        else mant_next = mprod[63:0];
                    end
                    else if (c == ".") mode_next = M_NDOT;
                    else if (c == "e" || c == "E") mode_next = M_NE;
                    else redo = 1'b1;
                end
                M_NDOT, M_NFRAC:
                begin
                    if (dig)
                    begin
                        if (mant_reg > MANT_LIM || mprod[67:64] != 4'd0)
                        begin
                            mant_next = MANT_MAX;
                            ovf_next = 1'b1;
                        end
                        else mant_next = mprod[63:0];
                        if (frac_reg != 16'hFFFF) frac_next = frac_reg + 16'd1;
                        else ovf_next = 1'b1;
                        mode_next = M_NFRAC;
                    end
                    else if (mode_reg == M_NFRAC && (c == "e" || c == "E")) mode_next = M_NE;
                    else redo = 1'b1;
                end
                M_NE, M_NESIGN, M_NEXP:
                begin
                    if (mode_reg == M_NE && c == "+") mode_next = M_NESIGN;
                    else if (mode_reg == M_NE && c == "-")
                    begin
                        esign_next = 1'b1;
                        mode_next = M_NESIGN;
                    end
                    else if (dig)
                    begin
                        if (eprod > 20'd65535)
                        begin
                            exp_next = 16'hFFFF;
                            ovf_next = 1'b1;
                        end
                        else exp_next = eprod[15:0];
                        mode_next = M_NEXP;
                    end
                    else redo = 1'b1;
                end
                default: redo = 1'b0;
            endcase
            if (redo)
            begin
                if (mode_reg == M_NSIGN || mode_reg == M_NDOT || mode_reg == M_NE ||
                    mode_reg == M_NESIGN)
                begin
                    tok[0].token_kind = TK_ERROR;
                    tok[0].error_code = ER_BAD_NUM;
                    tok_cnt = 2'd1;
                    mode_next = M_HALT;
                end
                else
                begin
                    tok_cnt = 2'd1;
                    mode_next = M_IDLE;
                    idle_run = 1'b1;
                end
            end
        end

        // Number token from the current accumulators (used when a byte ends the number).
        e = esign_reg ? -$signed({2'b00, exp_reg}) : $signed({2'b00, exp_reg});
        e = e - $signed({2'b00, frac_reg});
        esat = 1'b0;
        if (e > 18'sd32767)
        begin
            e = 18'sd32767;
            esat = 1'b1;
        end
        else if (e < -18'sd32768)
        begin
            e = -18'sd32768;
            esat = 1'b1;
        end
        if (redo && mode_next == M_IDLE)
        begin
            tok[0].token_kind  = TK_NUMBER;
            tok[0].is_negative = sign_reg;
            tok[0].mantissa    = mant_reg;
            tok[0].exponent    = e[15:0];
            tok[0].saturated   = ovf_reg | esat;
            sign_next = 1'b0;
            mant_next = '0;
            frac_next = '0;
            exp_next  = '0;
            esign_next= 1'b0;
            ovf_next  = 1'b0;
        end

        if (idle_run)
        begin
            case (c)
                "{", "}", "[", "]", ",", ":":
                begin
                    case (c)
                        "{": tok[tok_cnt[0]].token_kind = TK_LBRACE;
                        "}": tok[tok_cnt[0]].token_kind = TK_RBRACE;
                        "[": tok[tok_cnt[0]].token_kind = TK_LBRACKET;
                        "]": tok[tok_cnt[0]].token_kind = TK_RBRACKET;
                        ",": tok[tok_cnt[0]].token_kind = TK_COMMA;
                        default: tok[tok_cnt[0]].token_kind = TK_COLON;
                    endcase
                    tok_cnt = tok_cnt + 2'd1;
                end
                " ", "\t", "\r": tok_cnt = tok_cnt;
                "\n":
                begin
                    if (line_reg < LINE_MAX) line_next = line_reg + 1'b1;
                    nl = 1'b1;
                end
                "\"": mode_next = M_STR;
                "-":
                begin
                    sign_next = 1'b1;
                    mant_next = '0;
                    frac_next = '0;
                    exp_next  = '0;
                    esign_next= 1'b0;
                    ovf_next  = 1'b0;
                    mode_next = M_NSIGN;
                end
                "t", "f", "n":
                begin
                    ksel_next = (c == "t") ? 2'd0 : (c == "f") ? 2'd1 : 2'd2;
                    sub_next  = 3'd1;
                    mode_next = M_KEYW;
                end
                default:
                begin
                    if (dig)
                    begin
                        sign_next = 1'b0;
                        mant_next = {60'd0, d};
                        frac_next = '0;
                        exp_next  = '0;
                        esign_next= 1'b0;
                        ovf_next  = 1'b0;
                        mode_next = (c == "0") ? M_NZERO : M_NINT;
                    end
                    else
                    begin
                        tok[tok_cnt[0]].token_kind = TK_ERROR;
                        tok[tok_cnt[0]].error_code = ER_BAD_CHAR;
                        tok_cnt = tok_cnt + 2'd1;
                        mode_next = M_HALT;
                    end
                end
            endcase
        end

        for (int i = 0; i < 2; i++)
        begin
            tok[i].line_count   = 20'(line_reg);
            tok[i].column_count = 16'(col_reg);
        end

        if (in_last_reg)
        begin
            if (mode_next == M_NZERO || mode_next == M_NINT || mode_next == M_NFRAC ||
                mode_next == M_NEXP)
            begin
                // Accumulators after this byte give the final number.
                e = esign_next ? -$signed({2'b00, exp_next}) : $signed({2'b00, exp_next});
                e = e - $signed({2'b00, frac_next});
                esat = 1'b0;
                if (e > 18'sd32767)
                begin
                    e = 18'sd32767;
                    esat = 1'b1;
                end
                else if (e < -18'sd32768)
                begin
                    e = -18'sd32768;
                    esat = 1'b1;
                end
                tok[tok_cnt[0]] = '0;
                tok[tok_cnt[0]].token_kind   = TK_NUMBER;
                tok[tok_cnt[0]].is_negative  = sign_next;
                tok[tok_cnt[0]].mantissa     = mant_next;
                tok[tok_cnt[0]].exponent     = e[15:0];
                tok[tok_cnt[0]].saturated    = ovf_next | esat;
                tok[tok_cnt[0]].line_count   = 20'(line_next);
                tok[tok_cnt[0]].column_count = 16'(nxt);
                tok_cnt = tok_cnt + 2'd1;
            end
            else if (mode_next != M_IDLE && mode_next != M_HALT)
            begin
                tok[tok_cnt[0]] = '0;
                tok[tok_cnt[0]].token_kind   = TK_ERROR;
                tok[tok_cnt[0]].error_code   = ER_EARLY;
                tok[tok_cnt[0]].line_count   = 20'(line_next);
                tok[tok_cnt[0]].column_count = 16'(nxt);
                tok_cnt = tok_cnt + 2'd1;
            end
            mode_next = M_IDLE;
            sub_next  = 3'd0;
            ksel_next = 2'd0;
            sign_next = 1'b0;
            mant_next = '0;
            frac_next = '0;
            exp_next  = '0;
            esign_next= 1'b0;
            ovf_next  = 1'b0;
            line_next = LINE_BITS'(1);
            col_next  = '0;
        end
        else
        begin
            col_next = nl ? COLUMN_BITS'(1) : nxt;
        end

        if (tok_cnt == 2'd1) tok[0].final_of_run = 1'b1;
        if (tok_cnt == 2'd2) tok[1].final_of_run = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            in_byte_reg  <= '0;
            in_last_reg  <= 1'b0;
            mode_reg  <= M_IDLE;
            sub_reg   <= '0;
            ksel_reg  <= '0;
            sign_reg  <= 1'b0;
            mant_reg  <= '0;
            frac_reg  <= '0;
            exp_reg   <= '0;
            esign_reg <= 1'b0;
            ovf_reg   <= 1'b0;
            line_reg  <= LINE_BITS'(1);
            col_reg   <= '0;
        end
        else
        begin
            if (s_axis_tready)
            begin
                in_valid_reg <= s_axis_tvalid;
                in_byte_reg  <= s_axis_tdata;
                in_last_reg  <= s_axis_tlast;
            end
            if (fire)
            begin
                mode_reg  <= mode_next;
                sub_reg   <= sub_next;
                ksel_reg  <= ksel_next;
                sign_reg  <= sign_next;
                mant_reg  <= mant_next;
                frac_reg  <= frac_next;
                exp_reg   <= exp_next;
                esign_reg <= esign_next;
                ovf_reg   <= ovf_next;
                line_reg  <= line_next;
                col_reg   <= col_next;
            end
        end
    end

    // Output queue: pop from head, push up to two tokens behind what remains.
    always_ff @(posedge clk or negedge rst_n)
    begin
        logic [1:0] cnt;
        logic       head;
        if (!rst_n)
        begin
            q_cnt_reg  <= '0;
            q_head_reg <= 1'b0;
        end
        else
        begin
            cnt  = q_cnt_reg;
            head = q_head_reg;
            if (m_axis_tvalid && m_axis_tready)
            begin
                cnt  = cnt - 2'd1;
                head = ~head;
            end
            if (fire)
            begin
                if (tok_cnt != 2'd0)
                begin
                    q_data_reg[head ^ cnt[0]] <= tok[0];
                end
                if (tok_cnt == 2'd2)
                begin
                    q_data_reg[~(head ^ cnt[0])] <= tok[1];
                end
                cnt = cnt + tok_cnt;
            end
            q_cnt_reg  <= cnt;
            q_head_reg <= head;
        end
    end

    assign m_axis_tvalid = (q_cnt_reg != 2'd0);
    assign m_axis_tdata  = {3'd0, q_data_reg[q_head_reg].saturated,
                            q_data_reg[q_head_reg].exponent,
                            q_data_reg[q_head_reg].mantissa,
                            q_data_reg[q_head_reg].is_negative,
                            q_data_reg[q_head_reg].column_count,
                            q_data_reg[q_head_reg].line_count,
                            q_data_reg[q_head_reg].char_value,
                            q_data_reg[q_head_reg].error_code,
                            q_data_reg[q_head_reg].token_kind};
    assign m_axis_tlast  = q_data_reg[q_head_reg].final_of_run;

endmodule

### rtl/json_byte_lexer_checker.sv
// Port-level checker for the JSON byte lexer, bound to the top level.
// Depends on rtl/jbl_pkg.sv and rtl/json_byte_lexer.sv.
`timescale 1ns / 1ps
module json_byte_lexer_checker
(
    input logic         clk,
    input logic         rst_n,
    input logic         s_axis_tvalid,
    input logic         s_axis_tready,
    input logic         m_axis_tvalid,
    input logic         m_axis_tready,
    input logic [135:0] m_axis_tdata,
    input logic         m_axis_tlast
);
    import jbl_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("Output transaction changed while stalled.");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[3:0] <= TK_ERROR)
        else $error("Token kind out of range.");

    a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] != TK_ERROR |-> m_axis_tdata[6:4] == ER_NONE)
        else $error("Error code on a non-error token.");

    a_num_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[3:0] != TK_NUMBER |-> m_axis_tdata[132:51] == '0)
        else $error("Number fields set on a non-number token.");

    a_known: assert property (@(posedge clk) disable iff (!rst_n)
        !$isunknown({s_axis_tvalid, s_axis_tready, m_axis_tvalid}) &&
        (!m_axis_tvalid || !$isunknown(m_axis_tlast)))
        else $error("Handshake or last flag unknown.");

endmodule

bind json_byte_lexer json_byte_lexer_checker u_checker
(
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);

### tb/json_byte_lexer_tb.sv
// Testbench for the JSON byte lexer: drives byte streams and checks every token.
// A built-in model predicts tokens after the directed rows. Depends on rtl/jbl_pkg.sv.
`timescale 1ns / 1ps
module json_byte_lexer_tb;
    import jbl_pkg::*;

    typedef struct {
        logic [3:0]  kind;
        logic [2:0]  err;
        logic [7:0]  ch;
        logic [19:0] line;
        logic [15:0] col;
        logic        neg;
        logic [63:0] mant;
        logic [15:0] expo;
        logic        sat;
        logic        last;
    } tok_t;

    typedef struct {
        logic [7:0] b;
        logic       eod;
        logic       chk;
        tok_t       t;
    } row_t;

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [7:0]   s_axis_tdata;
    logic         s_axis_tlast;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [135:0] m_axis_tdata;
    logic         m_axis_tlast;

    json_byte_lexer i_dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    tok_t        expected_tokens[$];
    int          mismatch_count;
    int          cycle_count;
    int          hold_off;
    logic        stim_done;
    byte         byte_src[$];
    logic        eod_src[$];

    lex_mode_t   mode;
    logic [2:0]  sub;
    logic [1:0]  kw_sel;
    logic        sgn;
    logic [63:0] macc;
    logic [31:0] fdig;
    logic [31:0] eacc;
    logic        esgn;
    logic        ovf;
    logic [19:0] line_ctr;
    logic [15:0] col_ctr;
    tok_t        step_out[$];
    logic        nl_flag;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    task automatic report(input string what, input logic [63:0] got, input logic [63:0] exp_v);
        $display("mismatch at cycle %0d: %s got %0h expected %0h", cycle_count, what, got,
                 exp_v);
        mismatch_count++;
    endtask

    function automatic void lexer_reset();
        mode = M_IDLE;
        sub = 0;
        kw_sel = 0;
        sgn = 0; macc = 0; fdig = 0; eacc = 0; esgn = 0; ovf = 0;
        line_ctr = 1;
        col_ctr = 0;
    endfunction

    function automatic void clear_num();
        sgn = 0; macc = 0; fdig = 0; eacc = 0; esgn = 0; ovf = 0;
    endfunction

    function automatic void push_tok(input token_kind_t k, input error_code_t e,
                                     input logic [7:0] c, input logic [15:0] col,
                                     input logic n, input logic [63:0] m,
                                     input logic [15:0] x, input logic s);
        tok_t t;
        t.kind = k; t.err = e; t.ch = c; t.line = line_ctr; t.col = col;
        t.neg = n; t.mant = m; t.expo = x; t.sat = s; t.last = 0;
        if (step_out.size() < 2)
            step_out.insert(step_out.size(), t);
    endfunction

    function automatic void raise_error(input error_code_t e, input logic [15:0] col);
        push_tok(TK_ERROR, e, 0, col, 0, 0, 0, 0);
        mode = M_HALT;
    endfunction

    function automatic void acc_digit(input int d);
        if (macc > (64'hFFFF_FFFF_FFFF_FFFF - d) / 10)
        begin
            macc = 64'hFFFF_FFFF_FFFF_FFFF;
            ovf = 1;
        end
        else
            macc = macc * 10 + d;
    endfunction

    function automatic void acc_frac(input int d);
        acc_digit(d);
        if (fdig < 65535)
            fdig++;
        else
            ovf = 1;
    endfunction

    function automatic void acc_exp(input int d);
        logic [31:0] v;
        v = eacc * 10 + d;
        if (v > 65535)
        begin
            eacc = 65535;
            ovf = 1;
        end
        else
            eacc = v;
    endfunction

    function automatic void flush_number(input logic [15:0] col);
        int e;
        logic s;
        e = esgn ? -int'(eacc) : int'(eacc);
        s = ovf;
        e = e - int'(fdig);
        if (e > 32767)
        begin
            e = 32767;
            s = 1;
        end
        if (e < -32768)
        begin
            e = -32768;
            s = 1;
        end
        push_tok(TK_NUMBER, ER_NONE, 0, col, sgn, macc, e[15:0], s);
        clear_num();
        mode = M_IDLE;
    endfunction

    function automatic logic is_dig(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic [7:0] kw_letter(input logic [1:0] s, input int p);
        string w;
        if (s == 0)
            w = "true";
        else if (s == 1)
            w = "false";
        else
            w = "null";
        return (p < w.len()) ? w[p] : 8'h00;
    endfunction

    function automatic void between_tokens(input logic [7:0] c, input logic [15:0] col);
        case (c)
            "{": push_tok(TK_LBRACE, ER_NONE, 0, col, 0, 0, 0, 0);
            "}": push_tok(TK_RBRACE, ER_NONE, 0, col, 0, 0, 0, 0);
            "[": push_tok(TK_LBRACKET, ER_NONE, 0, col, 0, 0, 0, 0);
            "]": push_tok(TK_RBRACKET, ER_NONE, 0, col, 0, 0, 0, 0);
            ",": push_tok(TK_COMMA, ER_NONE, 0, col, 0, 0, 0, 0);
            ":": push_tok(TK_COLON, ER_NONE, 0, col, 0, 0, 0, 0);
            " ", 8'h09, 8'h0D: ;
            8'h0A:
            begin
                if (line_ctr != 20'hFFFFF)
                    line_ctr++;
                nl_flag = 1;
            end
            "\"": mode = M_STR;
            "-":
            begin
                clear_num();
                sgn = 1;
                mode = M_NSIGN;
            end
            "t", "f", "n":
            begin
                kw_sel = (c == "t") ? 0 : (c == "f") ? 1 : 2;
                sub = 1;
                mode = M_KEYW;
            end
            default:
            begin
                if (c == "0")
                begin
                    clear_num();
                    mode = M_NZERO;
                end
                else if (is_dig(c))
                begin
                    clear_num();
                    macc = c - "0";
                    mode = M_NINT;
                end
                else
                    raise_error(ER_BAD_CHAR, col);
            end
        endcase
    endfunction

    // Returns 0 when the byte closes the number and must be lexed again.
    function automatic logic number_continues(input logic [7:0] c, input logic [15:0] col);
        logic dg;
        int d;
        dg = is_dig(c);
        d = dg ? c - "0" : 0;
        case (mode)
            M_NSIGN:
            begin
                if (c == "0") mode = M_NZERO;
                else if (dg)
                begin
                    acc_digit(d);
                    mode = M_NINT;
                end
                else raise_error(ER_BAD_NUM, col);
                return 1;
            end
            M_NZERO, M_NINT:
            begin
                if (dg && mode == M_NINT)
                begin
                    acc_digit(d);
                    return 1;
                end
                if (c == ".")
                begin
                    mode = M_NDOT;
                    return 1;
                end
                if (c == "e" || c == "E")
                begin
                    mode = M_NE;
                    return 1;
                end
            end
            M_NDOT:
            begin
                if (dg)
                begin
                    acc_frac(d);
                    mode = M_NFRAC;
                end
                else raise_error(ER_BAD_NUM, col);
                return 1;
            end
            M_NFRAC:
            begin
                if (dg)
                begin
                    acc_frac(d);
                    return 1;
                end
                if (c == "e" || c == "E")
                begin
                    mode = M_NE;
                    return 1;
                end
            end
            M_NE:
            begin
                if (c == "+") mode = M_NESIGN;
                else if (c == "-")
                begin
                    esgn = 1;
                    mode = M_NESIGN;
                end
                else if (dg)
                begin
                    acc_exp(d);
                    mode = M_NEXP;
                end
                else raise_error(ER_BAD_NUM, col);
                return 1;
            end
            M_NESIGN:
            begin
                if (dg)
                begin
                    acc_exp(d);
                    mode = M_NEXP;
                end
                else raise_error(ER_BAD_NUM, col);
                return 1;
            end
            default:
            begin
                if (dg)
                begin
                    acc_exp(d);
                    return 1;
                end
            end
        endcase
        flush_number(col);
        return 0;
    endfunction

    function automatic void predict_tokens(input logic [7:0] c, input logic eod);
        logic [15:0] col;
        logic [15:0] nxt;
        logic [7:0] v;
        col = col_ctr;
        nxt = (col != 16'hFFFF) ? col + 1 : col;
        step_out.delete();
        nl_flag = 0;
        case (mode)
            M_IDLE: between_tokens(c, col);
            M_STR:
            begin
                if (c == "\\") mode = M_ESC;
                else if (c == "\"")
                begin
                    push_tok(TK_STR_END, ER_NONE, 0, col, 0, 0, 0, 0);
                    mode = M_IDLE;
                end
                else push_tok(TK_CHAR, ER_NONE, c, col, 0, 0, 0, 0);
            end
            M_ESC:
            begin
                mode = M_STR;
                v = 0;
                case (c)
                    "\"", "\\", "/": v = c;
                    "b": v = 8;
                    "f": v = 12;
                    "n": v = 10;
                    "r": v = 13;
                    "t": v = 9;
                    "u":
                    begin
                        mode = M_HEX;
                        sub = 0;
                    end
                    default: ;
                endcase
                if (v != 0)
                    push_tok(TK_CHAR, ER_NONE, v, col, 0, 0, 0, 0);
            end
            M_HEX:
            begin
                if (!(is_dig(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F")))
                    raise_error(ER_BAD_HEX, col);
                else
                begin
                    sub++;
                    if (sub >= 4) mode = M_STR;
                end
            end
            M_KEYW:
            begin
                if (c != kw_letter(kw_sel, sub))
                    raise_error(error_code_t'(5 + kw_sel), col);
                else
                begin
                    sub++;
                    if (kw_letter(kw_sel, sub) == 0)
                    begin
                        push_tok(token_kind_t'(9 + kw_sel), ER_NONE, 0, col, 0, 0, 0, 0);
                        mode = M_IDLE;
                    end
                end
            end
            M_NSIGN, M_NZERO, M_NINT, M_NDOT, M_NFRAC, M_NE, M_NESIGN, M_NEXP:
            begin
                if (!number_continues(c, col))
                    between_tokens(c, col);
            end
            default: ;
        endcase
        if (eod)
        begin
            case (mode)
                M_NZERO, M_NINT, M_NFRAC, M_NEXP: flush_number(nxt);
                M_IDLE, M_HALT: ;
                default: raise_error(ER_EARLY, nxt);
            endcase
        end
        if (step_out.size() > 0)
            step_out[step_out.size() - 1].last = 1;
        foreach (step_out[i])
            expected_tokens.insert(expected_tokens.size(), step_out[i]);
        if (eod)
            lexer_reset();
        else
            col_ctr = nl_flag ? 16'd1 : nxt;
    endfunction

    function automatic void queue_text(input string s, input logic close_doc);
        for (int i = 0; i < s.len(); i++)
        begin
            byte_src.insert(byte_src.size(), s[i]);
            eod_src.insert(eod_src.size(), close_doc && i == s.len() - 1);
        end
    endfunction

    function automatic string rand_digits(input int n);
        string s;
        s = "";
        for (int i = 0; i < n; i++)
            s = {s, string'(byte'("0" + $urandom_range(0, 9)))};
        return s;
    endfunction

    function automatic string rand_value();
        string s;
        string pool;
        pool = "ab\\\"/nrtu0Fz \n";
        case ($urandom_range(0, 9))
            0: return "true";
            1: return "false";
            2: return "null";
            3, 4:
            begin
                s = "";
                if ($urandom_range(0, 1))
                    s = "-";
                s = {s, rand_digits($urandom_range(1, 22))};
                if ($urandom_range(0, 1))
                    s = {s, ".", rand_digits($urandom_range(1, 6))};
                if ($urandom_range(0, 2) == 0)
                begin
                    if ($urandom_range(0, 1))
                        s = {s, "e"};
                    else
                        s = {s, "E"};
                    case ($urandom_range(0, 5))
                        0, 1: s = {s, "-"};
                        2, 3: s = {s, "+"};
                        default: ;
                    endcase
                    s = {s, rand_digits($urandom_range(1, 6))};
                end
                return s;
            end
            5, 6:
            begin
                s = "\"";
                repeat ($urandom_range(0, 6))
                begin
                    if ($urandom_range(0, 3) == 0)
                    begin
                        s = {s, "\\", string'(pool[$urandom_range(0, pool.len() - 1)])};
                        if (s[s.len() - 1] == "u")
                            s = {s, "0aF9"};
                    end
                    else
                        s = {s, string'(byte'($urandom_range(8'h20, 8'hFF)))};
                end
                return {s, "\""};
            end
            7: return "[1,{\"k\":null}]";
            default: return {"{\"a\":", rand_digits(2), "}"};
        endcase
    endfunction

    function automatic void queue_random_doc();
        string s;
        string sep;
        s = "";
        repeat ($urandom_range(1, 5))
        begin
            case ($urandom_range(0, 9))
                0, 1: sep = "\n";
                2, 3, 4, 5: sep = " ";
                default: sep = ",";
            endcase
            s = {s, rand_value(), sep};
        end
        if ($urandom_range(0, 3) == 0)
            s = {s, rand_value()};
        if ($urandom_range(0, 5) == 0)
            s = s.substr(0, $urandom_range(0, s.len() - 1));
        if ($urandom_range(0, 6) == 0)
            s[$urandom_range(0, s.len() - 1)] = byte'($urandom_range(0, 255));
        queue_text(s, 1'b1);
    endfunction

    initial
    begin
        row_t table_rows[$];
        row_t r;
        int idx;
        int burst;
        tok_t z;
        logic drained;
        logic held;
        z = '{default: '0};
        mismatch_count = 0;
        stim_done = 0;
        hold_off = 0;
        drained = 0;
        held = 0;
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = 8'h00;
        s_axis_tlast = 1'b0;
        lexer_reset();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed rows: the fixed expectations hold the first tokens after reset.
        r = '{b: "{", eod: 0, chk: 1, t: z};
        r.t.kind = TK_LBRACE; r.t.line = 1; r.t.col = 0; r.t.last = 1;
        table_rows.insert(table_rows.size(), r);
        r = '{b: 8'hFF, eod: 1, chk: 1, t: z};
        r.t.kind = TK_ERROR; r.t.err = ER_BAD_CHAR; r.t.line = 1; r.t.col = 1; r.t.last = 1;
        table_rows.insert(table_rows.size(), r);
        r = '{b: "\"", eod: 1, chk: 1, t: z};
        r.t.kind = TK_ERROR; r.t.err = ER_EARLY; r.t.line = 1; r.t.col = 1; r.t.last = 1;
        table_rows.insert(table_rows.size(), r);
        r = '{b: "9", eod: 1, chk: 1, t: z};
        r.t.kind = TK_NUMBER; r.t.mant = 9; r.t.line = 1; r.t.col = 1; r.t.last = 1;
        table_rows.insert(table_rows.size(), r);
        foreach (table_rows[i])
        begin
            byte_src.insert(byte_src.size(), table_rows[i].b);
            eod_src.insert(eod_src.size(), table_rows[i].eod);
        end
        queue_text("[\"\\u12G\"]", 1'b1);
        queue_text("01,-x", 1'b1);
        queue_text("18446744073709551616e70000 tru", 1'b1);
        queue_text("\"\\\"\\q\n\x00\" fals nul", 1'b1);
        queue_text("\n1.5E-3:", 1'b0);
        queue_text("false", 1'b1);

        idx = 0;
        while (byte_src.size() > 0 || idx < 1800)
        begin
            logic [7:0] b;
            logic e;
            if (idx >= 900 && !drained)
            begin
                drained = 1;
                s_axis_tvalid <= 1'b0;
                wait (expected_tokens.size() == 0);
                @(posedge clk);
            end
            if (idx >= 400 && !held)
            begin
                held = 1;
                hold_off = 300;
            end
            if (byte_src.size() == 0)
                queue_random_doc();
            b = byte_src.pop_front();
            e = eod_src.pop_front();
            s_axis_tvalid <= 1'b1;
            s_axis_tdata <= b;
            s_axis_tlast <= e;
            @(posedge clk);
            while (!s_axis_tready)
                @(posedge clk);
            if (idx < table_rows.size() && table_rows[idx].chk)
                expected_tokens.insert(expected_tokens.size(), table_rows[idx].t);
            else
            begin
                if (idx < table_rows.size())
                    predict_tokens(b, e);
                else
                    predict_tokens(b, e);
            end
            if (idx < table_rows.size())
            begin
                step_out.delete();
                lexer_reset();
            end
            idx++;
            burst = $urandom_range(0, 7);
            if (burst == 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 5)) @(posedge clk);
            end
        end
        s_axis_tvalid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        int phase;
        m_axis_tready = 1'b0;
        phase = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_off > 0)
            begin
                m_axis_tready <= 1'b0;
                hold_off--;
            end
            else
            begin
                phase = (phase + 1) % 64;
                m_axis_tready <= (phase < 32) ? 1'b1 : ($urandom_range(0, 2) != 0);
            end
        end
    end

    always @(posedge clk)
    begin
        tok_t w;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_tokens.size() == 0)
                report("token with none expected", m_axis_tdata[63:0], 0);
            else
            begin
                w = expected_tokens.pop_front();
                if (m_axis_tdata[3:0] !== w.kind) report("token_kind", m_axis_tdata[3:0], w.kind);
                if (m_axis_tdata[6:4] !== w.err) report("error_code", m_axis_tdata[6:4], w.err);
                if (m_axis_tdata[14:7] !== w.ch) report("char_value", m_axis_tdata[14:7], w.ch);
                if (m_axis_tdata[34:15] !== w.line)
                    report("line_count", m_axis_tdata[34:15], w.line);
                if (m_axis_tdata[50:35] !== w.col)
                    report("column_count", m_axis_tdata[50:35], w.col);
                if (m_axis_tdata[51] !== w.neg) report("is_negative", m_axis_tdata[51], w.neg);
                if (m_axis_tdata[115:52] !== w.mant)
                    report("mantissa", m_axis_tdata[115:52], w.mant);
                if (m_axis_tdata[131:116] !== w.expo)
                    report("exponent", m_axis_tdata[131:116], w.expo);
                if (m_axis_tdata[132] !== w.sat) report("saturated", m_axis_tdata[132], w.sat);
                if (m_axis_tlast !== w.last) report("final_of_run", m_axis_tlast, w.last);
            end
        end
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > 400000)
            begin
                $display("simulation failed");
                $finish;
            end
        end
    end

    initial
    begin
        wait (stim_done && expected_tokens.size() == 0);
        repeat (20) @(posedge clk);
        if (mismatch_count == 0 && expected_tokens.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
